// File: rtl/bmb_pkg.sv
`default_nettype none

package bmb_pkg;

  // Beat field widths
  localparam int REQ_BITS   = 2;
  localparam int FIELD_BITS = 12;
  localparam int IOU_BITS   = 17;
  localparam int FRAC_BITS  = 16;

  // Parameter defaults
  localparam int MAX_BOXES_DEF  = 32;
  localparam int COORD_BITS_DEF = 12;

  // Request codes; the fourth code is unused and ignored
  typedef enum logic [REQ_BITS-1:0] {
    REQ_CLEAR = 2'd0,
    REQ_LOAD  = 2'd1,
    REQ_QUERY = 2'd2
  } req_kind_t;

endpackage

`default_nettype wire

// File: rtl/bmb_if.sv
`default_nettype none

interface bmb_req_if;
  logic                             valid;
  logic                             ready;
  logic [bmb_pkg::REQ_BITS-1:0]     req_type;
  logic [bmb_pkg::FIELD_BITS-1:0]   box_x;
  logic [bmb_pkg::FIELD_BITS-1:0]   box_y;
  logic [bmb_pkg::FIELD_BITS-1:0]   box_width;
  logic [bmb_pkg::FIELD_BITS-1:0]   box_height;

  modport source (output valid, req_type, box_x, box_y, box_width, box_height,
                  input ready);
  modport sink (input valid, req_type, box_x, box_y, box_width, box_height,
                output ready);
endinterface

interface bmb_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [bmb_pkg::IOU_BITS-1:0]   best_iou;
  logic                           table_empty;
  logic                           table_overflowed;

  modport source (output valid, best_iou, table_empty, table_overflowed,
                  input ready);
  modport sink (input valid, best_iou, table_empty, table_overflowed,
                output ready);
endinterface

`default_nettype wire

// File: rtl/best_match_box_iou.sv
// A query runs START, then EXT, AREA, UNI, MULA, MULB per stored box, FIN, DSTART and
//   DIV, and returns one result beat; clear and load return no beat.
// Throughput: a request can be taken in the cycle the result rises; a waiting result
//   holds the divide step. Each box costs five steps. Clear, load: 1/cycle in IDLE.
// Reset: rst (synchronous, active high) empties the table and clears the overflow
//   flag; box storage is not erased and needs no clearing pass.
`default_nettype none

module best_match_box_iou #(
  parameter int MAX_BOXES  = bmb_pkg::MAX_BOXES_DEF,
  parameter int COORD_BITS = bmb_pkg::COORD_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  bmb_req_if.sink     req,
  bmb_rsp_if.source   rsp
);

  localparam int CB = COORD_BITS;          // coordinate
  localparam int EB = COORD_BITS + 1;      // right / bottom edge, no wrap
  localparam int AB = 2 * COORD_BITS;      // area
  localparam int UW = 2 * COORD_BITS + 1;  // union
  localparam int PW = AB + UW;             // cross product
  localparam int CW = $clog2(MAX_BOXES + 1);
  localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int QB = bmb_pkg::IOU_BITS;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_START  = 10'b00_0000_0010,
    S_EXT    = 10'b00_0000_0100,
    S_AREA   = 10'b00_0000_1000,
    S_UNI    = 10'b00_0001_0000,
    S_MULA   = 10'b00_0010_0000,
    S_MULB   = 10'b00_0100_0000,
    S_FIN    = 10'b00_1000_0000,
    S_DSTART = 10'b01_0000_0000,
    S_DIV    = 10'b10_0000_0000
  } state_t;

  state_t state, state_next;

  // Table bookkeeping
  logic [CW-1:0] box_count;
  logic          overflow_flag;
  logic          table_full;

  // Query rectangle
  logic [CB-1:0] qx, qy, qw, qh;
  logic [AB-1:0] qa;

  // Per-box working registers
  logic [CW-1:0]   idx;
  logic [4*CB-1:0] rd_data;
  logic [CB-1:0]   bx, by, bw, bh;
  logic [CB-1:0]   ix, iy, bw_r, bh_r;
  logic [AB-1:0]   inter, ba;
  logic [UW-1:0]   uni;
  logic [PW-1:0]   pa, pb;
  logic            cmp_pend;

  // Running best as a ratio best_inter / best_uni
  logic [AB-1:0] best_inter;
  logic [UW-1:0] best_uni;

  // Output register
  logic          rsp_valid;
  logic [QB-1:0] rsp_iou;
  logic          rsp_empty;
  logic          rsp_ovf;

  logic          req_fire;
  logic          is_load;
  logic          is_clear;
  logic          is_query;
  logic          last_box;
  logic          div_done;
  logic [QB-1:0] div_quot;
  logic          out_free;

  assign req.ready = (state == S_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign is_clear  = (req.req_type == bmb_pkg::REQ_CLEAR);
  assign is_load   = (req.req_type == bmb_pkg::REQ_LOAD);
  assign is_query  = (req.req_type == bmb_pkg::REQ_QUERY);
  assign table_full = (box_count == CW'(MAX_BOXES));
  assign last_box   = ((idx + CW'(1)) == box_count);
  assign out_free   = !rsp_valid || rsp.ready;

  // ---------------------------------------------------------------------------
  // Box store: loads write at the fill count, the sequencer prefetches one box
  // ahead so the registered read is ready when the next box starts.
  // ---------------------------------------------------------------------------
  logic          ram_rd_en;
  logic [AW-1:0] ram_rd_addr;

  assign ram_rd_en   = (state == S_START) || (state == S_EXT);
  assign ram_rd_addr = (state == S_START) ? '0 : AW'(idx + CW'(1));

  bmb_ram #(
    .WIDTH (4 * CB),
    .DEPTH (MAX_BOXES)
  ) u_store (
    .clk     (clk),
    .wr_en   (req_fire && is_load && !table_full),
    .wr_addr (box_count[AW-1:0]),
    .wr_data ({CB'(req.box_x), CB'(req.box_y), CB'(req.box_width),
               CB'(req.box_height)}),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (rd_data)
  );

  assign {bx, by, bw, bh} = rd_data;

  // Clear and load are settled in the accept cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      box_count     <= '0;
      overflow_flag <= 1'b0;
    end else if (req_fire) begin
      if (is_clear) begin
        box_count     <= '0;
        overflow_flag <= 1'b0;
      end else if (is_load) begin
        if (table_full) begin
          overflow_flag <= 1'b1;
        end else begin
          box_count <= box_count + CW'(1);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (req_fire && is_query) state_next = S_START;
      S_START:  state_next = (box_count == '0) ? S_DSTART : S_EXT;
      S_EXT:    state_next = S_AREA;
      S_AREA:   state_next = S_UNI;
      S_UNI:    state_next = S_MULA;
      S_MULA:   state_next = S_MULB;
      S_MULB:   state_next = last_box ? S_FIN : S_EXT;
      S_FIN:    state_next = S_DSTART;
      S_DSTART: state_next = S_DIV;
      S_DIV:    if (div_done && out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cmp_pend <= 1'b0;
    end else begin
      state    <= state_next;
      cmp_pend <= (state == S_MULB);
    end
  end

  // ---------------------------------------------------------------------------
  // Intersection extents, taken straight off the read data
  // ---------------------------------------------------------------------------
  logic [CB-1:0] left, top;
  logic [EB-1:0] right, bottom;
  logic [EB-1:0] q_right, q_bottom, b_right, b_bottom;

  always_comb begin
    q_right  = {1'b0, qx} + {1'b0, qw};
    q_bottom = {1'b0, qy} + {1'b0, qh};
    b_right  = {1'b0, bx} + {1'b0, bw};
    b_bottom = {1'b0, by} + {1'b0, bh};
    left     = (qx > bx) ? qx : bx;
    top      = (qy > by) ? qy : by;
    right    = (q_right < b_right) ? q_right : b_right;
    bottom   = (q_bottom < b_bottom) ? q_bottom : b_bottom;
  end

  // ---------------------------------------------------------------------------
  // Area multiplier: query area once in START, box area per box in AREA.
  // The intersection area has its own narrow multiplier in the same step.
  // ---------------------------------------------------------------------------
  logic [CB-1:0] am_a, am_b;
  logic [AB-1:0] am_p;

  assign am_a = (state == S_START) ? qw : bw_r;
  assign am_b = (state == S_START) ? qh : bh_r;
  assign am_p = am_a * am_b;

  // ---------------------------------------------------------------------------
  // Shared cross-product multiplier: candidate * best union in MULA,
  // best * candidate union in MULB.
  // ---------------------------------------------------------------------------
  logic [AB-1:0] xm_a;
  logic [UW-1:0] xm_b;
  logic [PW-1:0] xm_p;

  assign xm_a = (state == S_MULA) ? inter    : best_inter;
  assign xm_b = (state == S_MULA) ? best_uni : uni;
  assign xm_p = PW'(xm_a) * PW'(xm_b);

  always_ff @(posedge clk) begin
    if (req_fire && is_query) begin
      // Take coordinates modulo the coordinate range
      qx         <= CB'(req.box_x);
      qy         <= CB'(req.box_y);
      qw         <= CB'(req.box_width);
      qh         <= CB'(req.box_height);
      best_inter <= '0;
      best_uni   <= UW'(1);
    end else if (cmp_pend && (pa > pb)) begin
      // Candidate ratio beats the best: inter/uni > best_inter/best_uni
      best_inter <= inter;
      best_uni   <= uni;
    end

    unique case (state)
      S_START: begin
        qa  <= am_p;
        idx <= '0;
      end
      S_EXT: begin
        ix   <= ((right > {1'b0, left}) && (bottom > {1'b0, top})) ?
                CB'(right - {1'b0, left}) : '0;
        iy   <= ((right > {1'b0, left}) && (bottom > {1'b0, top})) ?
                CB'(bottom - {1'b0, top}) : '0;
        bw_r <= bw;
        bh_r <= bh;
      end
      S_AREA: begin
        inter <= AB'(ix) * AB'(iy);
        ba    <= am_p;
      end
      S_UNI: begin
        uni <= UW'(qa) + UW'(ba) - UW'(inter);
      end
      S_MULA: begin
        pa <= xm_p;
      end
      S_MULB: begin
        pb  <= xm_p;
        idx <= idx + CW'(1);
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Final ratio: one division of the winning pair
  // ---------------------------------------------------------------------------
  bmb_div #(
    .UW (UW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_DSTART),
    .num   (UW'(best_inter)),
    .den   (best_uni),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Output register: hold the beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((state == S_DIV) && div_done && out_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DIV) && div_done && out_free) begin
      rsp_iou   <= div_quot;
      rsp_empty <= (box_count == '0);
      rsp_ovf   <= overflow_flag;
    end
  end

  assign rsp.valid            = rsp_valid;
  assign rsp.best_iou         = rsp_iou;
  assign rsp.table_empty      = rsp_empty;
  assign rsp.table_overflowed = rsp_ovf;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    box_count <= CW'(MAX_BOXES))
    else $error("box count beyond table depth");

  a_best_le_one: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> ({1'b0, best_inter} <= {1'b0, best_uni}))
    else $error("best ratio above one");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_empty) |-> (rsp_iou == '0))
    else $error("empty table reported a nonzero match");

  a_beat_from_div: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_DIV) && $past(div_done))
    else $error("result beat without a finished division");

endmodule

`default_nettype wire

// File: rtl/bmb_ram.sv
`default_nettype none

module bmb_ram #(
  parameter  int WIDTH = 48,
  parameter  int DEPTH = 32,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                    clk,
  input  wire logic                    wr_en,
  input  wire logic [AW-1:0]           wr_addr,
  input  wire logic [WIDTH-1:0]        wr_data,
  input  wire logic                    rd_en,
  input  wire logic [AW-1:0]           rd_addr,
  output      logic [WIDTH-1:0]        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/bmb_div.sv
`default_nettype none

// Restoring divider for num <= den: quot = floor(num * 2^FRAC_BITS / den),
// one quotient bit per cycle, most significant first.
module bmb_div #(
  parameter int UW = 25
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [UW-1:0]                  num,
  input  wire logic [UW-1:0]                  den,
  output      logic                           done,
  output      logic [bmb_pkg::IOU_BITS-1:0]   quot
);

  localparam int QB = bmb_pkg::IOU_BITS;
  localparam int SW = $clog2(QB + 1);

  logic [UW:0]   rem;
  logic [UW:0]   trial;
  logic          ge;
  logic [SW-1:0] step;
  logic          run;

  // First bit compares the numerator as is; later bits shift in a zero
  always_comb begin
    trial = (step == '0) ? rem : {rem[UW-1:0], 1'b0};
    ge    = (trial >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else if (start) begin
      run  <= 1'b1;
      done <= 1'b0;
      step <= '0;
    end else if (run) begin
      step <= step + SW'(1);
      if (step == SW'(QB - 1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= {1'b0, num};
    end else if (run) begin
      rem  <= ge ? (trial - {1'b0, den}) : trial;
      quot <= {quot[QB-2:0], ge};
    end
  end

endmodule

`default_nettype wire
